>>> design/fbg_pkg.sv
// Package for the felt/ball/guide pixel classifier.
// Holds the byte and result types and the colour thresholds.
// No dependencies.
package fbg_pkg;

	typedef logic [7:0] byte_t;

	// classification result for one pixel
	typedef struct packed {
		logic  felt_hit;
		logic  ball_like;
		logic  white_like;
		logic  strong_colour;
		logic  pale_line;
		logic  line_like;
		logic  ball_mask_bit;
		logic  white_mask_bit;
		byte_t light_level;
		byte_t colour_spread;
	} class_t;

	// channel order codes
	localparam logic ORDER_RGB = 1'b0;
	localparam logic ORDER_BGR = 1'b1;

	// divide-by-three reciprocal: x*683 >> 11 is exact for x <= 765
	localparam int  DIV3_MUL   = 683;
	localparam int  DIV3_SHIFT = 11;

	// felt brightness window
	localparam byte_t FELT_LIGHT_LO = 8'd42;
	localparam byte_t FELT_LIGHT_HI = 8'd226;
	// yellowish and reddish exclusions
	localparam byte_t YEL_R_MIN = 8'd185;
	localparam byte_t YEL_G_MIN = 8'd145;
	localparam byte_t YEL_B_MAX = 8'd110;
	localparam byte_t RED_R_MIN = 8'd175;
	localparam byte_t RED_GB_MAX = 8'd105;
	// felt colour tests
	localparam byte_t GREY_SPREAD_MAX = 8'd78;
	localparam byte_t GREY_SLACK      = 8'd18;
	localparam byte_t GREEN_OVER_R    = 8'd16;
	localparam byte_t GREEN_UNDER_B   = 8'd22;
	localparam byte_t BLUE_OVER_R     = 8'd12;
	localparam byte_t BLUE_G_UNDER_R  = 8'd14;
	// ball tests
	localparam byte_t BRIGHT_LIGHT    = 8'd176;
	localparam byte_t BRIGHT_SPREAD   = 8'd48;
	localparam byte_t DARK_LIGHT      = 8'd58;
	localparam byte_t DARK_SPREAD     = 8'd45;
	localparam byte_t COL_SPREAD_MIN  = 8'd48;
	localparam byte_t COL_LIGHT_LO    = 8'd48;
	localparam byte_t COL_LIGHT_HI    = 8'd244;
	localparam byte_t WHITE_SPREAD    = 8'd52;
	localparam byte_t STRONG_SPREAD   = 8'd88;
	localparam byte_t STRONG_LIGHT_HI = 8'd238;
	// guide line tests
	localparam byte_t PALE_LIGHT      = 8'd154;
	localparam byte_t PALE_SPREAD     = 8'd76;
	localparam byte_t CYAN_GB_MIN     = 8'd136;
	localparam byte_t CYAN_R_MAX      = 8'd146;
	localparam byte_t VIOL_B_MIN      = 8'd124;
	localparam byte_t VIOL_R_MIN      = 8'd102;
	localparam byte_t VIOL_G_MAX      = 8'd132;

endpackage

>>> design/fbg_if.sv
// Stream interfaces for the pixel classifier: pixel in, classification out.
// Depends on fbg_pkg.
interface fbg_pixel_if;
	logic          valid;
	logic          ready;
	fbg_pkg::byte_t byte_zero;
	fbg_pkg::byte_t byte_one;
	fbg_pkg::byte_t byte_two;

	modport source (output valid, output byte_zero, output byte_one, output byte_two,
		input ready);
	modport sink (input valid, input byte_zero, input byte_one, input byte_two,
		output ready);
endinterface

interface fbg_result_if;
	logic           valid;
	logic           ready;
	logic           felt_hit;
	logic           ball_like;
	logic           white_like;
	logic           strong_colour;
	logic           pale_line;
	logic           line_like;
	logic           ball_mask_bit;
	logic           white_mask_bit;
	fbg_pkg::byte_t light_level;
	fbg_pkg::byte_t colour_spread;

	modport source (output valid, output felt_hit, output ball_like, output white_like,
		output strong_colour, output pale_line, output line_like, output ball_mask_bit,
		output white_mask_bit, output light_level, output colour_spread, input ready);
	modport sink (input valid, input felt_hit, input ball_like, input white_like,
		input strong_colour, input pale_line, input line_like, input ball_mask_bit,
		input white_mask_bit, input light_level, input colour_spread, output ready);
endinterface

>>> design/fbg_classify.sv
// Combinational pixel classification: channel order, brightness, spread, flags.
// Depends on fbg_pkg.
module fbg_classify (
	input  logic            pixel_order,
	input  fbg_pkg::byte_t  byte_zero,
	input  fbg_pkg::byte_t  byte_one,
	input  fbg_pkg::byte_t  byte_two,
	output fbg_pkg::class_t res
);
	import fbg_pkg::*;

	byte_t       r, g, b, hi, lo, light, spread;
	logic [9:0]  sum;
	logic [19:0] prod;
	logic        felt_ok, grey_blue, green, blue, felt;
	logic        ball, white, vivid, pale, line;

	always_comb begin
		unique case (pixel_order)
			ORDER_BGR: begin
				r = byte_two;
				b = byte_zero;
			end
			default: begin
				r = byte_zero;
				b = byte_two;
			end
		endcase
		g = byte_one;

		hi = (g > r) ? g : r;
		hi = (b > hi) ? b : hi;
		lo = (g < r) ? g : r;
		lo = (b < lo) ? b : lo;
		spread = hi - lo;

		sum   = 10'(r) + 10'(g) + 10'(b);
		prod  = 20'(sum) * 20'(DIV3_MUL);
		light = prod[DIV3_SHIFT +: 8];

		felt_ok = (light >= FELT_LIGHT_LO) && (light <= FELT_LIGHT_HI)
			&& !(r > YEL_R_MIN && g > YEL_G_MIN && b < YEL_B_MAX)
			&& !(r > RED_R_MIN && g < RED_GB_MAX && b < RED_GB_MAX);
		// b+g >= 2r-18, kept non-negative by moving the slack across
		grey_blue = (spread < GREY_SPREAD_MAX)
			&& ((10'(b) + 10'(g) + 10'(GREY_SLACK)) >= {1'b0, r, 1'b0});
		green = (9'(g) > 9'(r) + 9'(GREEN_OVER_R))
			&& (9'(g) + 9'(GREEN_UNDER_B) >= 9'(b));
		blue  = (9'(b) > 9'(r) + 9'(BLUE_OVER_R))
			&& (9'(g) + 9'(BLUE_G_UNDER_R) > 9'(r));
		felt  = felt_ok && (grey_blue || green || blue);

		ball = (light > BRIGHT_LIGHT && spread < BRIGHT_SPREAD)
			|| (light < DARK_LIGHT && spread < DARK_SPREAD)
			|| (spread > COL_SPREAD_MIN && light > COL_LIGHT_LO && light < COL_LIGHT_HI);
		white  = (light > BRIGHT_LIGHT) && (spread < WHITE_SPREAD);
		vivid  = (spread > STRONG_SPREAD) && (light > COL_LIGHT_LO)
			&& (light < STRONG_LIGHT_HI);
		pale   = (light > PALE_LIGHT) && (spread < PALE_SPREAD);
		line   = pale
			|| (g > CYAN_GB_MIN && b > CYAN_GB_MIN && r < CYAN_R_MAX)
			|| (b > VIOL_B_MIN && r > VIOL_R_MIN && g < VIOL_G_MAX);

		res.felt_hit       = felt;
		res.ball_like      = ball;
		res.white_like     = white;
		res.strong_colour  = vivid;
		res.pale_line      = pale;
		res.line_like      = line;
		res.ball_mask_bit  = ((ball && !felt) || vivid) && !pale;
		res.white_mask_bit = white && !felt;
		res.light_level    = light;
		res.colour_spread  = spread;
	end

endmodule

>>> design/felt_ball_guide_pixel_classifier_top.sv
// Top level of the felt/ball/guide pixel classifier: input register,
// classification logic, result register. Depends on fbg_pkg, fbg_if, fbg_classify.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+---------------------------------------
//  pixel    | in  | valid / ready   | byte_zero, byte_one (green), byte_two
//  result   | out | valid / ready   | eight flags, light_level, colour_spread
//  cfg      | in  | cfg_wr_en only  | cfg_wr_data = pixel_order
//
// One request in and one result out per clock when unstalled; a request passes
// through the pixel register, then the result register.
// Reset clears both valid flags and sets pixel_order to RGB order.
// A stall on result holds the result register; the pixel register still takes
// a request if it is empty or its contents move on that cycle.
module felt_ball_guide_pixel_classifier_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,
	fbg_pixel_if.sink    pixel,
	fbg_result_if.source result
);
	import fbg_pkg::*;

	logic   pixel_order_q;
	logic   valid_s1, valid_s2;
	byte_t  byte_zero_s1, byte_one_s1, byte_two_s1;
	class_t res_comb, res_s2;
	logic   adv_s2, adv_s1;

	// stage 2 moves when empty or drained; stage 1 when empty or moving on
	assign adv_s2      = !valid_s2 || result.ready;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign pixel.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_order_q <= ORDER_RGB;
		end else if (cfg_wr_en) begin
			pixel_order_q <= cfg_wr_data;
		end
	end

	// pixel register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pixel.valid) begin
			byte_zero_s1 <= pixel.byte_zero;
			byte_one_s1  <= pixel.byte_one;
			byte_two_s1  <= pixel.byte_two;
		end
	end

	fbg_classify u_classify (
		.pixel_order (pixel_order_q),
		.byte_zero   (byte_zero_s1),
		.byte_one    (byte_one_s1),
		.byte_two    (byte_two_s1),
		.res         (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign result.valid          = valid_s2;
	assign result.felt_hit       = res_s2.felt_hit;
	assign result.ball_like      = res_s2.ball_like;
	assign result.white_like     = res_s2.white_like;
	assign result.strong_colour  = res_s2.strong_colour;
	assign result.pale_line      = res_s2.pale_line;
	assign result.line_like      = res_s2.line_like;
	assign result.ball_mask_bit  = res_s2.ball_mask_bit;
	assign result.white_mask_bit = res_s2.white_mask_bit;
	assign result.light_level    = res_s2.light_level;
	assign result.colour_spread  = res_s2.colour_spread;

endmodule
